// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned ORDER_W  = 16;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned OCC_W    = 4;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [ORDER_W-1:0] order;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic valid;
  } cell_ctrl_t;

  // true when the held entry is served no later than the new one
  function automatic logic goes_before(entry_t held, entry_t cand);
    logic res;
    if (held.prio != cand.prio) begin
      res = held.prio > cand.prio;
    end else begin
      res = held.order <= cand.order;
    end
    return res;
  endfunction

endpackage

// ===== rtl/spq_if.sv =====
`timescale 1ns / 1ps
interface spq_req_if;
  import spq_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [PRIO_W-1:0]  priority_req;
  logic [ORDER_W-1:0] arrival_order;
  logic [TAG_W-1:0]   payload_tag;

  modport source (output valid, kind, priority_req, arrival_order, payload_tag, input ready);
  modport sink   (input valid, kind, priority_req, arrival_order, payload_tag, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [PRIO_W-1:0]  out_priority;
  logic [ORDER_W-1:0] out_order;
  logic [TAG_W-1:0]   out_tag;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_priority, out_order, out_tag, occupancy,
                  input ready);
  modport sink   (input valid, status, out_priority, out_order, out_tag, occupancy,
                  output ready);
endinterface

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_before_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output logic               before_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  assign before_o = ctrl_i.valid && goes_before(entry_q, new_i);
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !before_o) begin
      entry_d = left_before_i ? new_i : left_i;
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one insert or remove per cycle; every cell of the row updates in
// parallel, so rate is set by the single output register and its ready.
// Reset: rst_ni clears the occupancy count and the output valid; entry cells
// are not cleared and hold data only below the count.
module sorted_priority_queue (
  input  logic   clk_i,
  input  logic   rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  entry_t           new_w;
  entry_t           cell_q [CAPACITY];
  logic [CAPACITY-1:0] before_w;
  logic             accept_w, is_ins, is_rem, full_w, empty_w;

  logic             rsp_valid_q;
  status_e          status_q, status_d;
  entry_t           out_q, out_d;
  logic [OCC_W-1:0] occ_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept_w    = req_i.valid && req_i.ready;
  assign full_w      = count_q == CNT_W'(CAPACITY);
  assign empty_w     = count_q == '0;
  assign is_ins      = accept_w && (kind_e'(req_i.kind) == KIND_INSERT) && !full_w;
  assign is_rem      = accept_w && (kind_e'(req_i.kind) == KIND_REMOVE) && !empty_w;

  assign new_w.prio  = req_i.priority_req;
  assign new_w.order = req_i.arrival_order;
  assign new_w.tag   = req_i.payload_tag;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     left_e, right_e;
    logic       left_b;
    assign ctrl.ins   = is_ins;
    assign ctrl.rem   = is_rem;
    assign ctrl.valid = CNT_W'(i) < count_q;
    if (i == 0) begin : g_head
      assign left_e = new_w;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_b = before_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_i         (new_w),
      .left_i        (left_e),
      .left_before_i (left_b),
      .right_i       (right_e),
      .entry_o       (cell_q[i]),
      .before_o      (before_w[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    out_d    = '0;
    if (kind_e'(req_i.kind) == KIND_INSERT) begin
      if (full_w) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty_w) begin
        status_d = ST_EMPTY;
      end else begin
        count_d = count_q - 1'b1;
        out_d   = cell_q[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept_w) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      status_q <= status_d;
      out_q    <= out_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_priority = out_q.prio;
  assign rsp_o.out_order    = out_q.order;
  assign rsp_o.out_tag      = out_q.tag;
  assign rsp_o.occupancy    = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_before_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((before_w >> 1) & ~before_w) == '0)
    else $error("cell order flags not a prefix");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_ins |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("insert did not raise count");

  a_rem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rem |=> count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("remove did not lower count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && status_q == ST_EMPTY) |-> out_q == '0)
    else $error("empty remove returned data");

endmodule
